### hdl/json_string_unescape_core_macros.svh
// assertion macros for the json string unescape core
// clk and rst_n are taken from the module that uses them
`ifndef JSON_STRING_UNESCAPE_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every clock edge outside reset
`define JSU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jsu assertion failed");

// consequence checked in the cycle after the trigger
`define JSU_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("jsu assertion failed");

`else

`define JSU_ASSERT(label, prop)
`define JSU_ASSERT_NEXT(label, trig, cons)

`endif

`endif

### hdl/jsu_pkg.sv
package jsu_pkg;

    // results one input byte can cause, and the width of a count of them
    localparam int MAX_RESULTS = 4;
    localparam int COUNT_W     = 3;

    // status codes carried by the final result of a string
    localparam logic [1:0] STATUS_CONT     = 2'd0;
    localparam logic [1:0] STATUS_CLOSED   = 2'd1;
    localparam logic [1:0] STATUS_UNCLOSED = 2'd2;
    localparam logic [1:0] STATUS_NOT_STR  = 2'd3;

    // decoder mode
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_req;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [1:0] status;
    } out_item_t;

    // all results of one input byte, in order from index 0
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] item;
        logic [COUNT_W-1:0]          count;
    } batch_t;

endpackage

### hdl/jsu_stream_if.sv
interface jsu_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/jsu_decoder.sv
module jsu_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  jsu_pkg::in_item_t item,
    output jsu_pkg::batch_t   batch
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;
    localparam logic [15:0] CP_ONE_MAX = 16'h0080;
    localparam logic [15:0] CP_TWO_MAX = 16'h0800;

    // text decoded again when the input ends inside the hex digits
    typedef struct packed {
        logic [2:0][7:0] dec;
        logic [1:0]      k;
        logic            closed;
    } replay_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_B:    r = 8'h08;
            CH_F:    r = 8'h0C;
            CH_N:    r = 8'h0A;
            CH_R:    r = 8'h0D;
            CH_T:    r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic out_item_t make_item(input logic [7:0] b, input logic v,
                                            input logic l, input logic [1:0] s);
        out_item_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.last       = l;
        r.status     = s;
        return r;
    endfunction

    // at most three bytes, so at most three dependent steps
    function automatic replay_t replay(input logic [7:0] h0, input logic [7:0] h1,
                                       input logic [7:0] lb, input logic [1:0] cnt);
        replay_t         r;
        logic [2:0][7:0] src;
        logic [2:0]      i;
        logic [2:0]      m;
        logic            done;
        logic [7:0]      c;
        logic [7:0]      e;
        r      = '0;
        src[0] = (cnt == 2'd0) ? lb : h0;
        src[1] = (cnt == 2'd1) ? lb : h1;
        src[2] = lb;
        m      = {1'b0, cnt} + 3'd1;
        i      = 3'd0;
        done   = 1'b0;
        for (int s = 0; s < 3; s++) begin
            if (!done && i < m) begin
                c = src[i[1:0]];
                if (c == CH_QUOTE) begin
                    r.closed = 1'b1;
                    done     = 1'b1;
                end else if (c == CH_BSLASH && (i + 3'd1) < m) begin
                    e = src[i[1:0] + 2'd1];
                    if (e != CH_U) begin
                        r.dec[r.k] = escape_byte(e);
                        r.k        = r.k + 2'd1;
                    end
                    i = i + 3'd2;
                end else begin
                    r.dec[r.k] = c;
                    r.k        = r.k + 2'd1;
                    i          = i + 3'd1;
                end
            end
        end
        return r;
    endfunction

    mode_t           mode_reg, mode_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [11:0]     code_point_reg, code_point_next;
    logic [1:0][7:0] held_reg, held_next;

    logic [7:0]      c;
    logic            fin;
    replay_t         rp;
    logic [15:0]     cp_full;
    logic [2:0][7:0] enc;
    logic [1:0]      enc_k;

    assign c       = item.in_byte;
    assign fin     = item.final_req;
    assign rp      = replay(held_reg[0], held_reg[1], c, hex_count_reg);
    assign cp_full = {code_point_reg, hex_value(c)};

    // utf-8 encoding of the completed code point
    always_comb
    begin
        enc = '0;
        if (cp_full < CP_ONE_MAX) begin
            enc[0] = cp_full[7:0];
            enc_k  = 2'd1;
        end else if (cp_full < CP_TWO_MAX) begin
            enc[0] = UTF8_LEAD2 | {3'b000, cp_full[10:6]};
            enc[1] = UTF8_CONT | ({2'b00, cp_full[5:0]} & UTF8_MASK);
            enc_k  = 2'd2;
        end else begin
            enc[0] = UTF8_LEAD3 | {4'b0000, cp_full[15:12]};
            enc[1] = UTF8_CONT | ({2'b00, cp_full[11:6]} & UTF8_MASK);
            enc[2] = UTF8_CONT | ({2'b00, cp_full[5:0]} & UTF8_MASK);
            enc_k  = 2'd3;
        end
    end

    // next state
    always_comb
    begin
        mode_next       = mode_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        held_next       = held_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                mode_next = (c == CH_QUOTE && !fin) ? MODE_BODY : MODE_IDLE;
            end
            MODE_BODY:
            begin
                if (c == CH_QUOTE) mode_next = MODE_IDLE;
                else if (c == CH_BSLASH && !fin) mode_next = MODE_ESC;
                else if (fin) mode_next = MODE_IDLE;
            end
            MODE_ESC:
            begin
                if (c == CH_U) begin
                    mode_next       = fin ? MODE_IDLE : MODE_HEX;
                    hex_count_next  = 2'd0;
                    code_point_next = '0;
                end else begin
                    mode_next = fin ? MODE_IDLE : MODE_BODY;
                end
            end
            MODE_HEX:
            begin
                if (hex_count_reg != 2'd3 && !fin) begin
                    if (hex_count_reg != 2'd2) held_next[hex_count_reg[0]] = c;
                    code_point_next = {code_point_reg[7:0], hex_value(c)};
                    hex_count_next  = hex_count_reg + 2'd1;
                end else if (hex_count_reg != 2'd3) begin
                    mode_next = MODE_IDLE;
                end else begin
                    hex_count_next  = 2'd0;
                    code_point_next = '0;
                    mode_next       = fin ? MODE_IDLE : MODE_BODY;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // results of the current byte
    always_comb
    begin
        batch = '0;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (c != CH_QUOTE) begin
                    batch.item[0] = make_item(8'h00, 1'b0, 1'b1, STATUS_NOT_STR);
                    batch.count   = COUNT_W'(1);
                end else if (fin) begin
                    batch.item[0] = make_item(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                    batch.count   = COUNT_W'(1);
                end
            end
            MODE_BODY:
            begin
                if (c == CH_QUOTE) begin
                    batch.item[0] = make_item(8'h00, 1'b0, 1'b1, STATUS_CLOSED);
                    batch.count   = COUNT_W'(1);
                end else if (!(c == CH_BSLASH && !fin)) begin
                    batch.item[0] = make_item(c, 1'b1, fin,
                                              fin ? STATUS_UNCLOSED : STATUS_CONT);
                    batch.count   = COUNT_W'(1);
                end
            end
            MODE_ESC:
            begin
                if (c == CH_U) begin
                    if (fin) begin
                        batch.item[0] = make_item(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                        batch.count   = COUNT_W'(1);
                    end
                end else begin
                    batch.item[0] = make_item(escape_byte(c), 1'b1, fin,
                                              fin ? STATUS_UNCLOSED : STATUS_CONT);
                    batch.count   = COUNT_W'(1);
                end
            end
            MODE_HEX:
            begin
                if (hex_count_reg != 2'd3 && fin) begin
                    // input ended inside the digits: decode them as text
                    for (int j = 0; j < 3; j++) begin
                        if (j < int'(rp.k)) begin
                            batch.item[j] = make_item(rp.dec[j], 1'b1,
                                !rp.closed && j == int'(rp.k) - 1,
                                (!rp.closed && j == int'(rp.k) - 1) ?
                                    STATUS_UNCLOSED : STATUS_CONT);
                        end
                    end
                    if (rp.closed) begin
                        batch.item[rp.k] = make_item(8'h00, 1'b0, 1'b1, STATUS_CLOSED);
                        batch.count      = {1'b0, rp.k} + COUNT_W'(1);
                    end else if (rp.k == 2'd0) begin
                        batch.item[0] = make_item(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                        batch.count   = COUNT_W'(1);
                    end else begin
                        batch.count = {1'b0, rp.k};
                    end
                end else if (hex_count_reg == 2'd3) begin
                    // fourth digit: emit the utf-8 bytes
                    for (int j = 0; j < 3; j++) begin
                        if (j < int'(enc_k)) begin
                            batch.item[j] = make_item(enc[j], 1'b1,
                                fin && j == int'(enc_k) - 1,
                                (fin && j == int'(enc_k) - 1) ?
                                    STATUS_UNCLOSED : STATUS_CONT);
                        end
                    end
                    batch.count = {1'b0, enc_k};
                end
            end
            default:
            begin
                batch = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            hex_count_reg  <= 2'd0;
            code_point_reg <= '0;
        end else if (take) begin
            mode_reg       <= mode_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

    // held digit bytes
    always_ff @(posedge clk)
    begin
        if (take) begin
            held_reg <= held_next;
        end
    end

endmodule

### hdl/json_string_unescape_core.sv
// the first result of an accepted byte appears in the cycle after it is taken
// throughput: one byte per cycle while each byte gives at most one result and the
// receiver is ready; a byte that gives more results holds the input while the
// result queue drains one result per cycle, when decoded.ready is high
// reset: rst_n clears mode, digit count, code point and the result queue
`include "json_string_unescape_core_macros.svh"

module json_string_unescape_core (
    input  logic clk,
    input  logic rst_n,
    jsu_stream_if.sink   text,
    jsu_stream_if.source decoded
);
    import jsu_pkg::*;

    out_item_t [MAX_RESULTS-1:0] item_reg, item_next;
    logic [COUNT_W-1:0]          cnt_reg, cnt_next;
    batch_t                      batch;
    logic                        take;
    logic                        give;

    // input transaction when the queue is empty or empties this cycle
    assign text.ready    = (cnt_reg == '0) || (cnt_reg == COUNT_W'(1) && decoded.ready);
    assign take          = text.valid && text.ready;
    assign decoded.valid = (cnt_reg != '0);
    assign decoded.data  = item_reg[0];
    assign give          = decoded.valid && decoded.ready;

    jsu_decoder u_decoder (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (text.data),
        .batch (batch)
    );

    // result queue: load a new batch or shift out the head
    always_comb
    begin
        item_next = item_reg;
        cnt_next  = cnt_reg;
        if (take) begin
            item_next = batch.item;
            cnt_next  = batch.count;
        end else if (give) begin
            for (int j = 0; j < MAX_RESULTS - 1; j++) begin
                item_next[j] = item_reg[j + 1];
            end
            cnt_next = cnt_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // checks
    `JSU_ASSERT_NEXT(a_load_count, take, cnt_reg == $past(batch.count))
    `JSU_ASSERT(a_last_is_tail, (decoded.valid && decoded.data.last) |-> (cnt_reg == COUNT_W'(1)))
    `JSU_ASSERT(a_status_on_last, decoded.valid |-> ((decoded.data.status != STATUS_CONT) == decoded.data.last))
    `JSU_ASSERT(a_empty_byte_zero, (decoded.valid && !decoded.data.byte_valid) |-> (decoded.data.out_byte == 8'h00))

endmodule

### sim/tb_json_string_unescape_core.sv
module tb_json_string_unescape_core;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 320;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // one row of the directed table; result is checked as typed when typed is set
    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_req;
        logic       typed;
        out_item_t  result;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        // not a string, then a final opening quote
        '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_NOT_STR}},
        '{CH_QUOTE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_UNCLOSED}},
        // byte extremes inside a string
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, STATUS_CONT}},
        '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, STATUS_CONT}},
        // short escape
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{"b", 1'b0, 1'b0, '0},
        // two-byte utf-8 at the top of its range
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_U, 1'b0, 1'b0, '0},
        '{"0", 1'b0, 1'b0, '0},
        '{"7", 1'b0, 1'b0, '0},
        '{"f", 1'b0, 1'b0, '0},
        '{"F", 1'b0, 1'b0, '0},
        // non-hex digits, quote and backslash among them, three-byte utf-8
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_U, 1'b0, 1'b0, '0},
        '{"F", 1'b0, 1'b0, '0},
        '{"g", 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        // closing quote
        '{CH_QUOTE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_CLOSED}},
        // input ends inside the digits on a quote
        '{CH_QUOTE, 1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_U, 1'b0, 1'b0, '0},
        '{"1", 1'b0, 1'b0, '0},
        '{CH_QUOTE, 1'b1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    jsu_stream_if #(.data_t(in_item_t))  text_if ();
    jsu_stream_if #(.data_t(out_item_t)) dec_if ();

    json_string_unescape_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_if),
        .decoded (dec_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder shadow state
    mode_t       dec_mode;
    logic [2:0]  digit_cnt;
    logic [15:0] cp_acc;
    logic [7:0]  digit_buf [3];
    logic [7:0]  run_buf [4];
    int          run_len;

    out_item_t decoded_q [$];

    int items_sent;
    int error_count;
    int results_seen;
    int n_closed, n_unclosed, n_not_str;
    int utf8_len_cnt [1:3];
    int n_text_replay;
    bit quiet;
    bit hold_req;
    int hold_left;
    bit hold_taken;
    int stuck_cycles;

    function automatic logic [7:0] short_escape(logic [7:0] c);
        case (c)
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            default: return c;
        endcase
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 10);
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 10);
        return 4'h0;
    endfunction

    function automatic void push_result(logic [7:0] b, logic v, logic l, logic [1:0] s);
        out_item_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.last       = l;
        r.status     = s;
        decoded_q.push_back(r);
    endfunction

    // emit the bytes of run_buf; with fin the last one ends the string unclosed
    function automatic void push_run(bit fin);
        bit ends;
        for (int k = 0; k < run_len; k++)
        begin
            ends = fin && (k == run_len - 1);
            push_result(run_buf[k], 1'b1, ends, ends ? STATUS_UNCLOSED : STATUS_CONT);
        end
    endfunction

    // expected results of one accepted byte, advancing the shadow state
    function automatic void decode_byte(in_item_t it);
        logic [7:0]  c;
        logic        fin;
        logic [15:0] cp;
        logic [7:0]  src [4];
        int          m;
        int          i;
        bit          closed;
        c   = it.in_byte;
        fin = it.final_req;
        case (dec_mode)
            MODE_BODY:
            begin
                if (c == CH_QUOTE)
                begin
                    push_result(8'h00, 1'b0, 1'b1, STATUS_CLOSED);
                    dec_mode = MODE_IDLE;
                end
                else if (c == CH_BSLASH && !fin)
                    dec_mode = MODE_ESC;
                else
                begin
                    push_result(c, 1'b1, fin, fin ? STATUS_UNCLOSED : STATUS_CONT);
                    if (fin)
                        dec_mode = MODE_IDLE;
                end
            end
            MODE_ESC:
            begin
                if (c == CH_U)
                begin
                    if (fin)
                    begin
                        push_result(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                        dec_mode = MODE_IDLE;
                    end
                    else
                    begin
                        dec_mode  = MODE_HEX;
                        digit_cnt = '0;
                        cp_acc    = '0;
                    end
                end
                else
                begin
                    push_result(short_escape(c), 1'b1, fin,
                                fin ? STATUS_UNCLOSED : STATUS_CONT);
                    dec_mode = fin ? MODE_IDLE : MODE_BODY;
                end
            end
            MODE_HEX:
            begin
                if (digit_cnt < 3 && !fin)
                begin
                    digit_buf[digit_cnt] = c;
                    cp_acc    = {cp_acc[11:0], hex_nibble(c)};
                    digit_cnt = digit_cnt + 3'd1;
                end
                else if (digit_cnt < 3)
                begin
                    // input ended mid escape: held digits and this byte become text
                    m = 0;
                    for (int j = 0; j < digit_cnt; j++)
                    begin
                        src[m] = digit_buf[j];
                        m++;
                    end
                    src[m] = c;
                    m++;
                    i       = 0;
                    closed  = 1'b0;
                    run_len = 0;
                    while (i < m && !closed)
                    begin
                        if (src[i] == CH_QUOTE)
                            closed = 1'b1;
                        else if (src[i] == CH_BSLASH && i + 1 < m)
                        begin
                            if (src[i + 1] != CH_U)
                            begin
                                run_buf[run_len] = short_escape(src[i + 1]);
                                run_len++;
                            end
                            i += 2;
                        end
                        else
                        begin
                            run_buf[run_len] = src[i];
                            run_len++;
                            i++;
                        end
                    end
                    if (closed)
                    begin
                        push_run(1'b0);
                        push_result(8'h00, 1'b0, 1'b1, STATUS_CLOSED);
                    end
                    else if (run_len == 0)
                        push_result(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                    else
                        push_run(1'b1);
                    n_text_replay++;
                    dec_mode = MODE_IDLE;
                end
                else
                begin
                    // fourth digit: utf-8 encode the code point
                    cp = {cp_acc[11:0], hex_nibble(c)};
                    if (cp < 16'h0080)
                    begin
                        run_buf[0] = cp[7:0];
                        run_len    = 1;
                    end
                    else if (cp < 16'h0800)
                    begin
                        run_buf[0] = 8'hC0 | 8'(cp >> 6);
                        run_buf[1] = 8'h80 | {2'b00, cp[5:0]};
                        run_len    = 2;
                    end
                    else
                    begin
                        run_buf[0] = 8'hE0 | 8'(cp >> 12);
                        run_buf[1] = 8'h80 | {2'b00, cp[11:6]};
                        run_buf[2] = 8'h80 | {2'b00, cp[5:0]};
                        run_len    = 3;
                    end
                    push_run(fin);
                    utf8_len_cnt[run_len]++;
                    digit_cnt = '0;
                    cp_acc    = '0;
                    dec_mode  = fin ? MODE_IDLE : MODE_BODY;
                end
            end
            default:
            begin
                dec_mode = MODE_IDLE;
                if (c != CH_QUOTE)
                    push_result(8'h00, 1'b0, 1'b1, STATUS_NOT_STR);
                else if (fin)
                    push_result(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                else
                    dec_mode = MODE_BODY;
            end
        endcase
    endfunction

    // offer one transaction from a falling edge, return at the falling edge after it
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
        int base;
        if (!quiet && $urandom_range(0, 99) < 30)
        begin
            text_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.data  <= it;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        base = decoded_q.size();
        decode_byte(it);
        if (typed)
        begin
            while (decoded_q.size() > base)
                void'(decoded_q.pop_back());
            decoded_q.push_back(typed_res);
        end
        items_sent++;
        @(negedge clk);
    endtask

    // a \u digit: mostly hex, sometimes quote, backslash or any byte
    function automatic logic [7:0] digit_byte(logic [3:0] nib);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            if (nib < 10)
                return 8'h30 + 8'(nib);
            return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
        end
        if (r < 90)
            return CH_QUOTE;
        if (r < 95)
            return CH_BSLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    // one quoted string with random content and a random way of ending
    task automatic send_random_string();
        logic [7:0]  seq [$];
        logic [7:0]  b;
        logic [15:0] cp;
        int          kind;
        int          end_sel;
        int          sel;
        bit          fin_last;
        seq.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 7))
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH);
                seq.push_back(b);
            end
            else if (kind < 60)
            begin
                seq.push_back(CH_BSLASH);
                case ($urandom_range(0, 4))
                    0:       seq.push_back("b");
                    1:       seq.push_back("f");
                    2:       seq.push_back("n");
                    3:       seq.push_back("r");
                    default: seq.push_back("t");
                endcase
            end
            else if (kind < 70)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_U);
                seq.push_back(CH_BSLASH);
                seq.push_back(b);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       cp = 16'($urandom_range(0, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                seq.push_back(CH_BSLASH);
                seq.push_back(CH_U);
                for (int k = 3; k >= 0; k--)
                    seq.push_back(digit_byte(cp[k*4 +: 4]));
            end
        end

        // ending: close, cut short, or stop in the middle of an escape
        end_sel  = $urandom_range(0, 99);
        fin_last = 1'b1;
        if (end_sel < 65)
        begin
            seq.push_back(CH_QUOTE);
            fin_last = ($urandom_range(0, 4) == 0);
        end
        else if (end_sel < 80)
            fin_last = 1'b1;
        else if (end_sel < 87)
            seq.push_back(CH_BSLASH);
        else if (end_sel < 93)
        begin
            seq.push_back(CH_BSLASH);
            seq.push_back(CH_U);
        end
        else
        begin
            seq.push_back(CH_BSLASH);
            seq.push_back(CH_U);
            repeat ($urandom_range(0, 2))
                seq.push_back(digit_byte(4'($urandom_range(0, 15))));
            sel = $urandom_range(0, 3);
            if (sel == 0)
                seq.push_back(CH_QUOTE);
            else if (sel == 1)
                seq.push_back(CH_BSLASH);
            else if (sel == 2)
                seq.push_back(digit_byte(4'($urandom_range(0, 15))));
            else
                seq.push_back(8'($urandom_range(0, 255)));
        end

        for (int k = 0; k < seq.size(); k++)
            send_item('{seq[k], fin_last && (k == seq.size() - 1)}, 1'b0, '0);
    endtask

    task automatic report_error(input string why, input out_item_t want, input out_item_t got);
        error_count++;
        if (error_count <= 10)
            $display("%s at %0t: expected byte %02h valid %0d last %0d status %0d,",
                     why, $time, want.out_byte, want.byte_valid, want.last, want.status,
                     " got byte %02h valid %0d last %0d status %0d",
                     got.out_byte, got.byte_valid, got.last, got.status);
    endtask

    // receiver: random ready, one long hold-off, a quiet stretch
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            dec_if.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            dec_if.ready <= 1'b0;
        end
        else if (quiet)
            dec_if.ready <= 1'b1;
        else
            dec_if.ready <= ($urandom_range(0, 99) >= 30);
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        out_item_t got;
        if (rst_n && dec_if.valid && dec_if.ready)
        begin
            got = dec_if.data;
            results_seen++;
            if (got.last && got.status == STATUS_CLOSED)
                n_closed++;
            if (got.last && got.status == STATUS_UNCLOSED)
                n_unclosed++;
            if (got.last && got.status == STATUS_NOT_STR)
                n_not_str++;
            if (decoded_q.size() == 0)
                report_error("unexpected result", '0, got);
            else
            begin
                want = decoded_q.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.last !== want.last || got.status !== want.status)
                    report_error("mismatch", want, got);
            end
        end
    end

    // watchdog on cycles with no input transaction
    always @(posedge clk)
    begin
        if (text_if.valid && text_if.ready)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d cycles without an input transaction, %0d results outstanding",
                     stuck_cycles, decoded_q.size());
            $display("FAIL json_string_unescape_core");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        text_if.valid = 1'b0;
        text_if.data  = '0;
        dec_if.ready  = 1'b0;
        dec_mode      = MODE_IDLE;
        digit_cnt     = '0;
        cp_acc        = '0;
        run_len       = 0;
        items_sent    = 0;
        error_count   = 0;
        results_seen  = 0;
        n_closed      = 0;
        n_unclosed    = 0;
        n_not_str     = 0;
        n_text_replay = 0;
        utf8_len_cnt  = '{0, 0, 0};
        quiet         = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        stuck_cycles  = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item('{DIRECTED[i].in_byte, DIRECTED[i].final_req},
                      DIRECTED[i].typed, DIRECTED[i].result);

        // random strings with some stray bytes between them
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            quiet = (items_sent >= 200 && items_sent < 300);
            if (items_sent >= 120)
                hold_req = 1'b1;
            if ($urandom_range(0, 9) == 0)
                send_item('{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))}, 1'b0, '0);
            else
                send_random_string();
        end
        quiet = 1'b0;
        text_if.valid <= 1'b0;

        // drain, then allow for any stray late result
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d results: %0d strings closed,",
                 items_sent, results_seen, n_closed,
                 " %0d cut short, %0d not a string", n_unclosed, n_not_str);
        $display("unicode escapes: %0d one-byte, %0d two-byte, %0d three-byte;",
                 utf8_len_cnt[1], utf8_len_cnt[2], utf8_len_cnt[3],
                 " %0d cut escapes decoded as text", n_text_replay);
        if (error_count == 0 && decoded_q.size() == 0)
            $display("PASS json_string_unescape_core");
        else
            $display("FAIL json_string_unescape_core");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/jsu_pkg.sv
hdl/jsu_stream_if.sv
hdl/jsu_decoder.sv
hdl/json_string_unescape_core.sv
sim/tb_json_string_unescape_core.sv
